// ===== rtl/core/cyctmr_pkg.sv =====
// Shared types and constants for the two-mode cycle timer.
package cyctmr_pkg;

  localparam int SEC_W  = 7;
  localparam int SUB_W  = 4;
  localparam int TEMP_W = 10;
  localparam int CHAR_W = 8;
  localparam int THR_W  = 10;
  localparam int ADC_W  = 10;

  localparam logic [1:0] FUNC_LONG_START  = 2'd0;
  localparam logic [1:0] FUNC_SHORT_START = 2'd1;
  localparam logic [1:0] FUNC_SEC_TICK    = 2'd2;
  localparam logic [1:0] FUNC_FAST_TICK   = 2'd3;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_LONG  = 2'd1;
  localparam logic [1:0] MODE_SHORT = 2'd2;

  localparam logic [1:0] REG_LONG_DUR  = 2'd0;
  localparam logic [1:0] REG_SHORT_DUR = 2'd1;
  localparam logic [1:0] REG_SUBTICKS  = 2'd2;
  localparam logic [1:0] REG_THRESHOLD = 2'd3;

  localparam logic [SEC_W-1:0]  LONG_DUR_RST  = 7'd60;
  localparam logic [SEC_W-1:0]  SHORT_DUR_RST = 7'd10;
  localparam logic [SUB_W-1:0]  SUBTICKS_RST  = 4'd4;
  localparam logic [THR_W-1:0]  THRESHOLD_RST = 10'd500;

  localparam logic [TEMP_W-1:0] TEMP_FULL  = 10'd1000;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic             refresh;
    logic [1:0]       mode;
    logic [SEC_W-1:0] seconds;
  } ctrl_res_t;

  typedef struct packed {
    logic [TEMP_W-1:0] tenths;
    logic [CHAR_W-1:0] hundreds;
    logic [CHAR_W-1:0] tens;
    logic [CHAR_W-1:0] units;
    logic [CHAR_W-1:0] tenth;
  } temp_res_t;

endpackage

// ===== rtl/core/cyctmr_ctrl.sv =====
// Timer mode, second count and sub-tick count with per-request update.
module cyctmr_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [1:0]                     func,
  input  logic [cyctmr_pkg::SEC_W-1:0]   long_dur,
  input  logic [cyctmr_pkg::SEC_W-1:0]   short_dur,
  input  logic [cyctmr_pkg::SUB_W-1:0]   subticks,
  output cyctmr_pkg::ctrl_res_t          res
);
  import cyctmr_pkg::*;

  logic [1:0]       mode_r, mode_nxt;
  logic [SEC_W-1:0] sec_r, sec_nxt;
  logic [SUB_W-1:0] sub_r, sub_nxt;
  logic [SUB_W-1:0] sub_inc;
  logic             take_sec;
  logic             refresh;

  assign sub_inc = sub_r + 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    sec_nxt  = sec_r;
    sub_nxt  = sub_r;
    take_sec = 1'b0;
    refresh  = 1'b0;
    case (func)
      FUNC_LONG_START: begin
        if (mode_r == MODE_IDLE) begin
          sec_nxt  = long_dur;
          mode_nxt = MODE_LONG;
          refresh  = 1'b1;
        end
      end
      FUNC_SHORT_START: begin
        if (mode_r == MODE_IDLE) begin
          sec_nxt  = short_dur;
          mode_nxt = MODE_SHORT;
          sub_nxt  = '0;
          refresh  = 1'b1;
        end
      end
      FUNC_SEC_TICK: begin
        if (mode_r == MODE_LONG) begin
          take_sec = 1'b1;
          refresh  = 1'b1;
        end
      end
      default: begin
        if (mode_r == MODE_SHORT) begin
          refresh = 1'b1;
          if (sub_inc >= subticks) begin
            sub_nxt  = '0;
            take_sec = 1'b1;
          end else begin
            sub_nxt = sub_inc;
          end
        end
      end
    endcase
    if (take_sec) begin
      if (sec_r <= SEC_W'(1)) begin
        sec_nxt  = '0;
        mode_nxt = MODE_IDLE;
      end else begin
        sec_nxt = sec_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      sec_r  <= '0;
      sub_r  <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      sec_r  <= sec_nxt;
      sub_r  <= sub_nxt;
    end
  end

  assign res.refresh = refresh;
  assign res.mode    = mode_nxt;
  assign res.seconds = sec_nxt;

endmodule

// ===== rtl/core/cyctmr_temp.sv =====
// Converter scaling to tenths of a degree, registered with the request, and ASCII digit split.
module cyctmr_temp #(
  parameter int ADC_BITS = 10
) (
  input  logic                         clk,
  input  logic                         load,
  input  logic [cyctmr_pkg::ADC_W-1:0] adc_sample,
  output cyctmr_pkg::temp_res_t        res
);
  import cyctmr_pkg::*;

  localparam int AW   = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
  localparam int PW   = AW + 10;
  localparam int RW   = AW + 12;
  localparam logic [ADC_BITS-1:0] FULL = {ADC_BITS{1'b1}};

  logic [AW-1:0]     adc;
  logic [PW-1:0]     prod;
  logic [PW:0]       est_sum;
  logic [TEMP_W:0]   q0;
  logic [RW-1:0]     rem;
  logic [TEMP_W:0]   q;
  logic [TEMP_W-1:0] temp_r;
  logic              hund;
  logic [TEMP_W-1:0] low;
  logic [23:0]       t_mul;
  logic [3:0]        t_dig;
  logic [6:0]        r2;
  logic [17:0]       u_mul;
  logic [3:0]        u_dig;
  logic [3:0]        d_dig;

  assign adc  = adc_sample[AW-1:0];
  assign prod = PW'(adc) * PW'(TEMP_FULL);

  // x / (2^N - 1) ~ (x + x/2^N) / 2^N, at most one low; fix with one compare
  assign est_sum = {1'b0, prod} + (PW + 1)'(prod >> ADC_BITS);
  assign q0      = (TEMP_W + 1)'(est_sum >> ADC_BITS);
  assign rem     = RW'(prod) + RW'(q0) - (RW'(q0) << ADC_BITS);
  assign q       = (rem >= RW'(FULL)) ? q0 + 1'b1 : q0;

  // scaled value is taken with the request; digits are split after the register
  always_ff @(posedge clk) begin
    if (load) begin
      temp_r <= q[TEMP_W-1:0];
    end
  end

  assign hund  = (temp_r == TEMP_FULL);
  assign low   = hund ? '0 : temp_r;
  assign t_mul = 24'(low) * 24'd5243;
  assign t_dig = t_mul[22:19];
  assign r2    = 7'(low - 10'(t_dig) * 10'd100);
  assign u_mul = 18'(r2) * 18'd205;
  assign u_dig = u_mul[14:11];
  assign d_dig = 4'(r2 - 7'(u_dig) * 7'd10);

  assign res.tenths   = temp_r;
  assign res.hundreds = hund ? (CHAR_ZERO + 8'd1) : CHAR_SPACE;
  assign res.tens     = CHAR_ZERO + 8'(t_dig);
  assign res.units    = CHAR_ZERO + 8'(u_dig);
  assign res.tenth    = CHAR_ZERO + 8'(d_dig);

endmodule

// ===== rtl/core/two_mode_cycle_timer_with_heater.sv =====
// Top level of the two-mode cycle timer with heater drive.
//
//  channel | direction | handshake            | payload
//  in_     | slave     | in_tvalid/in_tready  | in_tdata: func, adc_sample
//  out_    | master    | out_tvalid/out_tready| out_tdata: timer, temperature, heater
//  cfg_    | write     | cfg_we               | cfg_index, cfg_wdata
//
// Two register stages: input register (temperature scaled ahead of it), then
// timer/digit logic into the output register. A result is valid once its request
// has passed both registers; one request per cycle sustained while the output is not stalled.
// Requests that change nothing produce no output item.
// Reset (synchronous, active low) idles the timer and empties both stages.
// A stalled output holds the input stage; the input keeps accepting while
// its stage can move on in the same cycle.
module two_mode_cycle_timer_with_heater #(
  parameter int ADC_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // func[1:0], adc_sample[11:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // seconds_left[6:0], active_mode[8:7],
                                  // temp_valid[9], temp_tenths[19:10],
                                  // hundreds_char[27:20], tens_char[35:28],
                                  // units_char[43:36], tenths_char[51:44],
                                  // heater_on[52]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_wdata
);
  import cyctmr_pkg::*;

  logic [SEC_W-1:0]  long_dur_r;
  logic [SEC_W-1:0]  short_dur_r;
  logic [SUB_W-1:0]  subticks_r;
  logic [THR_W-1:0]  thresh_r;

  logic              s1_v_r;
  logic [1:0]        s1_func_r;
  logic              step;

  ctrl_res_t         ctrl_res;
  temp_res_t         temp_res;

  logic              out_v_r, out_v_nxt;
  logic [52:0]       out_d_r, out_d_nxt;
  logic              active;
  logic              heater;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_dur_r  <= LONG_DUR_RST;
      short_dur_r <= SHORT_DUR_RST;
      subticks_r  <= SUBTICKS_RST;
      thresh_r    <= THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LONG_DUR:  long_dur_r  <= cfg_wdata[SEC_W-1:0];
        REG_SHORT_DUR: short_dur_r <= cfg_wdata[SEC_W-1:0];
        REG_SUBTICKS:  subticks_r  <= cfg_wdata[SUB_W-1:0];
        REG_THRESHOLD: thresh_r    <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign step      = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_func_r <= in_tdata[1:0];
    end
  end

  cyctmr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .func      (s1_func_r),
    .long_dur  (long_dur_r),
    .short_dur (short_dur_r),
    .subticks  (subticks_r),
    .res       (ctrl_res)
  );

  cyctmr_temp #(.ADC_BITS(ADC_BITS)) u_temp (
    .clk        (clk),
    .load       (in_tready && in_tvalid),
    .adc_sample (in_tdata[11:2]),
    .res        (temp_res)
  );

  assign active = (ctrl_res.mode != MODE_IDLE);
  assign heater = active && (temp_res.tenths > thresh_r);

  always_comb begin
    out_d_nxt = '0;
    out_d_nxt[6:0] = ctrl_res.seconds;
    out_d_nxt[8:7] = ctrl_res.mode;
    if (active) begin
      out_d_nxt[9]     = 1'b1;
      out_d_nxt[19:10] = temp_res.tenths;
      out_d_nxt[27:20] = temp_res.hundreds;
      out_d_nxt[35:28] = temp_res.tens;
      out_d_nxt[43:36] = temp_res.units;
      out_d_nxt[51:44] = temp_res.tenth;
    end
    out_d_nxt[52] = heater;
  end

  always_comb begin
    out_v_nxt = out_v_r && !out_tready;
    if (step && ctrl_res.refresh) begin
      out_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && ctrl_res.refresh) begin
      out_d_r <= out_d_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, out_d_r};

endmodule

// ===== rtl/core/cyctmr_chk.sv =====
// Port-level checks for the cycle timer, bound to the top level.
module cyctmr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output request changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8:7] == 2'd0 |->
      out_tdata[9] == 1'b0 && out_tdata[52] == 1'b0 && out_tdata[6:0] == 7'd0)
    else $error("idle result carries timer or heater data");

  a_active_sampled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8:7] != 2'd0 |->
      out_tdata[9] == 1'b1 && out_tdata[8:7] != 2'd3 && out_tdata[19:10] <= 10'd1000)
    else $error("active result without valid temperature");

endmodule

bind two_mode_cycle_timer_with_heater cyctmr_chk u_chk (.*);

// ===== test/cyctmr_readout_check.sv =====
// Stream monitor for the cycle timer: predicts each refresh readout and compares it.
module cyctmr_readout_check
  import cyctmr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [15:0]       in_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [55:0]       out_tdata,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [9:0]        cfg_wdata,
  output int unsigned       errors,
  output int unsigned       pending,
  output logic [1:0]        timer_mode
);

  typedef struct {
    logic [SEC_W-1:0]  secs;
    logic [1:0]        mode;
    logic              valid;
    logic [TEMP_W-1:0] tenths;
    logic [CHAR_W-1:0] ch_hund;
    logic [CHAR_W-1:0] ch_tens;
    logic [CHAR_W-1:0] ch_unit;
    logic [CHAR_W-1:0] ch_tenth;
    logic              heat;
  } readout_t;

  readout_t readouts_due[$];

  logic [SEC_W-1:0] long_dur, short_dur, secs;
  logic [SUB_W-1:0] subs_per_sec, subs;
  logic [THR_W-1:0] thr;
  logic [1:0]       cur_mode;
  logic             heat;

  initial begin
    errors     = 0;
    pending    = 0;
    timer_mode = MODE_IDLE;
  end

  task automatic report(input string msg);
    if (errors < 40) $display("[%0t] readout check: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  function automatic void drop_second();
    if (secs <= 1) begin
      secs     = '0;
      cur_mode = MODE_IDLE;
    end else begin
      secs = secs - 1'b1;
    end
  endfunction

  // Advances the timer by one request; returns 1 when it causes a refresh.
  function automatic bit step_timer(input logic [1:0] fn, input logic [ADC_W-1:0] adc,
                                    output readout_t r);
    bit          hit;
    int unsigned t;
    hit = 1'b0;
    case (fn)
      FUNC_LONG_START: begin
        if (cur_mode == MODE_IDLE) begin
          secs     = long_dur;
          cur_mode = MODE_LONG;
          hit      = 1'b1;
        end
      end
      FUNC_SHORT_START: begin
        if (cur_mode == MODE_IDLE) begin
          secs     = short_dur;
          cur_mode = MODE_SHORT;
          subs     = '0;
          hit      = 1'b1;
        end
      end
      FUNC_SEC_TICK: begin
        if (cur_mode == MODE_LONG) begin
          drop_second();
          hit = 1'b1;
        end
      end
      default: begin
        if (cur_mode == MODE_SHORT) begin
          subs = subs + 1'b1;
          if (subs >= subs_per_sec) begin
            subs = '0;
            drop_second();
          end
          hit = 1'b1;
        end
      end
    endcase
    r.secs     = secs;
    r.mode     = cur_mode;
    r.valid    = 1'b0;
    r.tenths   = '0;
    r.ch_hund  = '0;
    r.ch_tens  = '0;
    r.ch_unit  = '0;
    r.ch_tenth = '0;
    heat       = 1'b0;
    if (hit && cur_mode != MODE_IDLE) begin
      t          = (adc * 1000) / 1023;
      r.valid    = 1'b1;
      r.tenths   = t[TEMP_W-1:0];
      r.ch_hund  = (t / 1000 > 0) ? 8'(t / 1000) + CHAR_ZERO : CHAR_SPACE;
      r.ch_tens  = 8'((t % 1000) / 100) + CHAR_ZERO;
      r.ch_unit  = 8'((t % 100) / 10) + CHAR_ZERO;
      r.ch_tenth = 8'(t % 10) + CHAR_ZERO;
      heat       = (t > thr);
    end
    r.heat = heat;
    return hit;
  endfunction

  always @(posedge clk) begin : watch
    readout_t got, want;
    if (!rst_n) begin
      long_dur     = LONG_DUR_RST;
      short_dur    = SHORT_DUR_RST;
      subs_per_sec = SUBTICKS_RST;
      thr          = THRESHOLD_RST;
      cur_mode     = MODE_IDLE;
      secs         = '0;
      subs         = '0;
      heat         = 1'b0;
      readouts_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LONG_DUR:  long_dur     = cfg_wdata[SEC_W-1:0];
          REG_SHORT_DUR: short_dur    = cfg_wdata[SEC_W-1:0];
          REG_SUBTICKS:  subs_per_sec = cfg_wdata[SUB_W-1:0];
          default:       thr          = cfg_wdata[THR_W-1:0];
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.secs     = out_tdata[6:0];
        got.mode     = out_tdata[8:7];
        got.valid    = out_tdata[9];
        got.tenths   = out_tdata[19:10];
        got.ch_hund  = out_tdata[27:20];
        got.ch_tens  = out_tdata[35:28];
        got.ch_unit  = out_tdata[43:36];
        got.ch_tenth = out_tdata[51:44];
        got.heat     = out_tdata[52];
        if (readouts_due.size() == 0) begin
          report($sformatf("unexpected readout 0x%014h", out_tdata));
        end else begin
          want = readouts_due.pop_front();
          check_field("seconds_left", got.secs, want.secs);
          check_field("active_mode", got.mode, want.mode);
          check_field("temp_valid", got.valid, want.valid);
          check_field("temp_tenths", got.tenths, want.tenths);
          check_field("hundreds_char", got.ch_hund, want.ch_hund);
          check_field("tens_char", got.ch_tens, want.ch_tens);
          check_field("units_char", got.ch_unit, want.ch_unit);
          check_field("tenths_char", got.ch_tenth, want.ch_tenth);
          check_field("heater_on", got.heat, want.heat);
        end
      end
      if (in_tvalid && in_tready) begin
        if (step_timer(in_tdata[1:0], in_tdata[11:2], want)) readouts_due.push_back(want);
      end
    end
    pending    = readouts_due.size();
    timer_mode = cur_mode;
  end

endmodule

// ===== test/tb_top.sv =====
// Top of the cycle timer testbench: clock, reset, request and register stimulus, verdict.
module tb_top;
  import cyctmr_pkg::*;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // func[1:0], adc_sample[11:2]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;         // seconds_left[6:0], active_mode[8:7], temp_valid[9],
                                  // temp_tenths[19:10], hundreds_char[27:20],
                                  // tens_char[35:28], units_char[43:36],
                                  // tenths_char[51:44], heater_on[52]
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [9:0]  cfg_wdata  = '0;

  int unsigned errors, pending;
  logic [1:0]  timer_mode;

  int unsigned      sent    = 0;
  bit               gaps_on = 1'b1;
  logic [SEC_W-1:0] long_sel  = LONG_DUR_RST;
  logic [SEC_W-1:0] short_sel = SHORT_DUR_RST;
  logic [SUB_W-1:0] sub_sel   = SUBTICKS_RST;
  logic [THR_W-1:0] thr_sel   = THRESHOLD_RST;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  two_mode_cycle_timer_with_heater i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cyctmr_readout_check i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending),
    .timer_mode(timer_mode)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [ADC_W-1:0] rand_adc();
    int r, a;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: a = 0;
      1: a = 1;
      2: a = 1022;
      default: a = 1023;
    endcase
    if (r < 10) return a[ADC_W-1:0];
    if (r < 25) begin
      a = (thr_sel * 1023) / 1000 + $urandom_range(0, 2) - 1;
      return (a < 0) ? '0 : (a > 1023) ? '1 : a[ADC_W-1:0];
    end
    return ADC_W'($urandom_range(0, 1023));
  endfunction

  // Receiver: ready runs broken by stalls, mostly short.
  initial begin : ready_gen
    int stall;
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat (($urandom_range(0, 19) == 0) ? 200 : $urandom_range(1, 20)) @(posedge clk);
      stall = pick_gap();
      if (gaps_on && stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic send_event(input logic [1:0] fn, input logic [ADC_W-1:0] adc);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, adc, fn};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic drain(input int settle);
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [9:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [9:0] l, input logic [9:0] s, input logic [9:0] sb,
                           input logic [9:0] th);
    put_reg(REG_LONG_DUR, l);
    put_reg(REG_SHORT_DUR, s);
    put_reg(REG_SUBTICKS, sb);
    put_reg(REG_THRESHOLD, th);
    cfg_we    <= 1'b0;
    long_sel  = l[SEC_W-1:0];
    short_sel = s[SEC_W-1:0];
    sub_sel   = sb[SUB_W-1:0];
    thr_sel   = th;
  endtask

  // Keeps ticking whatever mode is running until the timer is idle.
  task automatic finish_cycle();
    logic [1:0] m;
    forever begin
      in_tvalid <= 1'b0;
      @(negedge clk);
      m = timer_mode;
      @(posedge clk);
      if (m == MODE_IDLE) break;
      send_event((m == MODE_LONG) ? FUNC_SEC_TICK : FUNC_FAST_TICK, rand_adc());
    end
  endtask

  task automatic run_cycle(input bit short_mode);
    int         ticks, extra;
    logic [1:0] tick_fn;
    extra = $urandom_range(0, 2);
    if (short_mode) begin
      tick_fn = FUNC_FAST_TICK;
      ticks   = ((short_sel == 0) ? 1 : short_sel) * ((sub_sel == 0) ? 1 : sub_sel);
      send_event(FUNC_SHORT_START, rand_adc());
    end else begin
      tick_fn = FUNC_SEC_TICK;
      ticks   = (long_sel == 0) ? 1 : long_sel;
      send_event(FUNC_LONG_START, rand_adc());
    end
    repeat (ticks) begin
      if ($urandom_range(0, 99) < 12) send_event(2'($urandom_range(0, 3)), rand_adc());
      else send_event(tick_fn, rand_adc());
    end
    finish_cycle();
    repeat (extra) begin
      send_event($urandom_range(0, 1) ? FUNC_SEC_TICK : FUNC_FAST_TICK, rand_adc());
    end
  endtask

  function automatic logic [9:0] pick_duration();
    int         r;
    logic [6:0] d;
    r = $urandom_range(0, 99);
    if (r < 75) d = 7'($urandom_range(0, 8));
    else if (r < 95) d = 7'($urandom_range(9, 30));
    else d = 7'($urandom_range(31, 127));
    return {3'($urandom), d};
  endfunction

  function automatic logic [9:0] pick_threshold();
    case ($urandom_range(0, 9))
      0: return 10'd0;
      1: return 10'd1000;
      2: return 10'd1023;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  initial begin : stimulus
    logic [9:0] l, s, sb;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values, idle ignores, digit and heater edges
    send_event(FUNC_SEC_TICK, 10'd700);
    send_event(FUNC_FAST_TICK, 10'd300);
    send_event(FUNC_SHORT_START, 10'd1023);
    send_event(FUNC_FAST_TICK, 10'd0);
    send_event(FUNC_FAST_TICK, 10'd512);
    send_event(FUNC_FAST_TICK, 10'd513);
    send_event(FUNC_LONG_START, 10'd100);
    send_event(FUNC_SHORT_START, 10'd200);
    send_event(FUNC_SEC_TICK, 10'd999);
    finish_cycle();
    drain(4);

    // zero durations, zero subticks, zero threshold, masked writes
    load_regs(10'h380, 10'h000, 10'h3F0, 10'd0);
    send_event(FUNC_LONG_START, 10'd1);
    send_event(FUNC_SEC_TICK, 10'd1023);
    send_event(FUNC_SHORT_START, 10'd2);
    send_event(FUNC_FAST_TICK, 10'd5);
    send_event(FUNC_LONG_START, 10'd1023);
    send_event(FUNC_SHORT_START, 10'd1023);
    send_event(FUNC_SEC_TICK, 10'd1023);
    drain(4);

    load_regs(10'h381, 10'h382, 10'h3FF, 10'd1023);
    send_event(FUNC_LONG_START, 10'd1023);
    send_event(FUNC_SEC_TICK, 10'd1023);
    send_event(FUNC_SHORT_START, 10'd1023);
    finish_cycle();
    drain(4);

    load_regs(10'd127, 10'd99, 10'd1, 10'd1000);
    run_cycle(1'b0);
    run_cycle(1'b1);
    drain(4);

    while (sent < 1700) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      l  = pick_duration();
      s  = pick_duration();
      sb = {6'($urandom), 4'((s[6:0] > 30) ? $urandom_range(0, 2) : $urandom_range(0, 15))};
      load_regs(l, s, sb, pick_threshold());
      repeat ($urandom_range(3, 8)) begin
        run_cycle($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) drain(1);
      end
      drain(4);
    end

    gaps_on = 1'b1;
    drain(8);
    if (errors == 0 && pending == 0) begin
      $display("PASS two_mode_cycle_timer_with_heater");
    end else begin
      $display("FAIL two_mode_cycle_timer_with_heater");
    end
    $finish;
  end

  initial begin : watchdog
    #30000000;
    $display("FAIL two_mode_cycle_timer_with_heater");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/cyctmr_pkg.sv
rtl/core/cyctmr_ctrl.sv
rtl/core/cyctmr_temp.sv
rtl/core/two_mode_cycle_timer_with_heater.sv
rtl/core/cyctmr_chk.sv
test/cyctmr_readout_check.sv
test/tb_top.sv
